>>> hdl/dmal_pkg.sv
package dmal_pkg;

  // averaging window
  localparam int WINDOW_DEPTH = 5;

  localparam int DIST_W = 10;
  localparam int READ_W = 11;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // sum of the window stays below 1024 * WINDOW_DEPTH
  localparam int SUM_W  = DIST_W + CNT_W;
  localparam int STEP_W = $clog2(DIST_W + 1);

  // stream packing
  localparam int IN_TDATA_W  = ((3 * READ_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DIST_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // configuration registers
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FALLBACK_DISTANCE   = 3'd0,
    CFG_LATCH_ON_THRESHOLD  = 3'd1,
    CFG_LATCH_OFF_THRESHOLD = 3'd2,
    CFG_FORCED_DISTANCE     = 3'd3,
    CFG_FORCED_VELOCITY     = 3'd4
  } cfg_reg_t;

  localparam logic [DIST_W-1:0] FALLBACK_DISTANCE_RST   = 10'd50;
  localparam logic [DIST_W-1:0] LATCH_ON_THRESHOLD_RST  = 10'd10;
  localparam logic [DIST_W-1:0] LATCH_OFF_THRESHOLD_RST = 10'd20;
  localparam logic [DIST_W-1:0] FORCED_DISTANCE_RST     = 10'd5;
  localparam logic [DIST_W-1:0] FORCED_VELOCITY_RST     = 10'd10;

endpackage

>>> hdl/distance_median_average_latch.sv
// Path: from the accepting edge through PUSH, SUM (one step per window entry filled
// after this word, 1 to WINDOW_DEPTH), DIV and FINISH; a missing echo skips SUM and DIV.
// One word at a time. The one shared adder/subtractor handles one window entry per
// cycle in SUM, then one quotient bit per cycle in DIV. A waiting result word holds the
// next word in FINISH until it is taken.
// Reset (rst, synchronous): filter state cleared, registers back to their defaults.
module distance_median_average_latch (
  input  logic                                 clk,
  input  logic                                 rst,
  // reading_first [10:0], reading_second [21:11], reading_third [32:22]
  input  logic [dmal_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // reported_distance [9:0], reported_velocity [19:10]
  output logic [dmal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // threat_latched [0], echo_missing [1]
  output logic [dmal_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we,
  input  logic [dmal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmal_pkg::DIST_W-1:0]          cfg_wdata
);

  localparam int DW = dmal_pkg::DIST_W;
  localparam int RW = dmal_pkg::READ_W;
  localparam int CW = dmal_pkg::CNT_W;
  localparam int SW = dmal_pkg::SLOT_W;
  localparam int UW = dmal_pkg::SUM_W;
  localparam int TW = dmal_pkg::STEP_W;

  typedef enum logic [2:0] {
    IDLE,
    PUSH,
    SUM,
    DIV,
    FINISH
  } state_t;

  state_t state;

  logic [DW-1:0] fallback_distance;
  logic [DW-1:0] latch_on_threshold;
  logic [DW-1:0] latch_off_threshold;
  logic [DW-1:0] forced_distance;
  logic [DW-1:0] forced_velocity;

  logic [DW-1:0] window [dmal_pkg::WINDOW_DEPTH];
  logic [SW-1:0] write_slot;
  logic [CW-1:0] fill_count;
  logic [DW-1:0] previous_distance;
  logic          latch_flag;

  logic [RW-1:0] rd_a, rd_b, rd_c;
  logic          missing;
  logic [SW-1:0] idx;
  logic [UW-1:0] sum;
  logic [CW-1:0] rem;
  logic [DW-1:0] quot;
  logic [TW-1:0] div_step;
  logic [DW-1:0] distance;

  logic [DW-1:0] rep_distance;
  logic [DW-1:0] rep_velocity;
  logic          rep_latched;
  logic          rep_missing;

  // median of three non-negative readings
  logic [DW-1:0] ma, mb, mc, median;

  always_comb begin
    ma = rd_a[DW-1:0];
    mb = rd_b[DW-1:0];
    mc = rd_c[DW-1:0];
    if ((ma <= mb && mb <= mc) || (mc <= mb && mb <= ma)) begin
      median = mb;
    end else if ((mb <= ma && ma <= mc) || (mc <= ma && ma <= mb)) begin
      median = ma;
    end else begin
      median = mc;
    end
  end

  // shared adder/subtractor: accumulates the window, then does the restoring divide
  logic [UW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [UW:0]   alu_res;
  logic          div_ge;
  logic [CW:0]   div_trial;

  assign div_trial = {rem, quot[DW-1]};

  always_comb begin
    if (state == DIV) begin
      alu_a   = UW'(div_trial);
      alu_b   = UW'(fill_count);
      alu_sub = 1'b1;
    end else begin
      alu_a   = sum;
      alu_b   = UW'(window[idx]);
      alu_sub = 1'b0;
    end
    alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (UW + 1)'(alu_sub);
  end

  // carry out of the subtract means trial >= divisor
  assign div_ge = alu_res[UW];

  // latch and result selection
  logic          latch_next;
  logic [DW-1:0] out_d, out_v;

  always_comb begin
    latch_next = latch_flag;
    if (distance <= latch_on_threshold) begin
      latch_next = 1'b1;
    end else if (distance > latch_off_threshold) begin
      latch_next = 1'b0;
    end
    if (latch_next) begin
      out_d = forced_distance;
      out_v = forced_velocity;
    end else begin
      out_d = distance;
      out_v = (previous_distance > distance) ? previous_distance - distance : '0;
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tdata  = dmal_pkg::OUT_TDATA_W'({rep_velocity, rep_distance});
  assign m_axis_tuser  = {rep_missing, rep_latched};

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= IDLE;
      fallback_distance   <= dmal_pkg::FALLBACK_DISTANCE_RST;
      latch_on_threshold  <= dmal_pkg::LATCH_ON_THRESHOLD_RST;
      latch_off_threshold <= dmal_pkg::LATCH_OFF_THRESHOLD_RST;
      forced_distance     <= dmal_pkg::FORCED_DISTANCE_RST;
      forced_velocity     <= dmal_pkg::FORCED_VELOCITY_RST;
      for (int i = 0; i < dmal_pkg::WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
      write_slot          <= '0;
      fill_count          <= '0;
      previous_distance   <= '0;
      latch_flag          <= 1'b0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dmal_pkg::CFG_FALLBACK_DISTANCE:   fallback_distance   <= cfg_wdata;
          dmal_pkg::CFG_LATCH_ON_THRESHOLD:  latch_on_threshold  <= cfg_wdata;
          dmal_pkg::CFG_LATCH_OFF_THRESHOLD: latch_off_threshold <= cfg_wdata;
          dmal_pkg::CFG_FORCED_DISTANCE:     forced_distance     <= cfg_wdata;
          dmal_pkg::CFG_FORCED_VELOCITY:     forced_velocity     <= cfg_wdata;
          default: ;
        endcase
      end

      // FINISH reloads the output word itself
      if (m_axis_tvalid && m_axis_tready && state != FINISH) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            rd_a    <= s_axis_tdata[RW-1:0];
            rd_b    <= s_axis_tdata[2*RW-1:RW];
            rd_c    <= s_axis_tdata[3*RW-1:2*RW];
            missing <= s_axis_tdata[RW-1] | s_axis_tdata[2*RW-1] | s_axis_tdata[3*RW-1];
            state   <= PUSH;
          end
        end
        PUSH: begin
          if (missing) begin
            distance <= fallback_distance;
            state    <= FINISH;
          end else begin
            window[write_slot] <= median;
            if (write_slot == SW'(dmal_pkg::WINDOW_DEPTH - 1)) begin
              write_slot <= '0;
            end else begin
              write_slot <= write_slot + 1'b1;
            end
            if (fill_count != CW'(dmal_pkg::WINDOW_DEPTH)) begin
              fill_count <= fill_count + 1'b1;
            end
            sum   <= '0;
            idx   <= '0;
            state <= SUM;
          end
        end
        SUM: begin
          sum <= alu_res[UW-1:0];
          idx <= idx + 1'b1;
          if (CW'(idx) == fill_count - 1'b1) begin
            // quotient fits in DW bits, so the top bits are the opening remainder
            rem      <= alu_res[UW-1:DW];
            quot     <= alu_res[DW-1:0];
            div_step <= '0;
            state    <= DIV;
          end
        end
        DIV: begin
          rem      <= div_ge ? alu_res[CW-1:0] : div_trial[CW-1:0];
          quot     <= {quot[DW-2:0], div_ge};
          div_step <= div_step + 1'b1;
          if (div_step == TW'(DW - 1)) begin
            distance <= {quot[DW-2:0], div_ge};
            state    <= FINISH;
          end
        end
        FINISH: begin
          // hold while the previous word still waits
          if (!m_axis_tvalid || m_axis_tready) begin
            latch_flag        <= latch_next;
            previous_distance <= distance;
            rep_distance      <= out_d;
            rep_velocity      <= out_v;
            rep_latched       <= latch_next;
            rep_missing       <= missing;
            m_axis_tvalid     <= 1'b1;
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(dmal_pkg::WINDOW_DEPTH))
    else $error("fill count past window depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < SW'(dmal_pkg::WINDOW_DEPTH))
    else $error("write slot out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == DIV |-> rem < fill_count)
    else $error("divide remainder not below divisor");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("word accepted while busy or result too early");

  a_sum_window: assert property (@(posedge clk) disable iff (rst)
    state == SUM |-> fill_count != '0)
    else $error("summing an empty window");

endmodule
